>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the block checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> design/gcms_pkg.sv
// ----------------------------------------------------------------------------
// gcms_pkg
// types and constants for the gap-constrained max-sum block
// ----------------------------------------------------------------------------
package gcms_pkg;

  localparam int TOTAL_W  = 48;
  localparam int AMOUNT_W = 20;
  localparam int GAP_W    = 9;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 1;

  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [AMOUNT_W-1:0] amount_t;
  typedef logic [GAP_W-1:0]    gap_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 1'b1;

  // shared unit operations
  typedef logic [0:0] alu_op_t;
  localparam alu_op_t OP_MAX = 1'b0;
  localparam alu_op_t OP_ADD = 1'b1;

  typedef struct packed {
    alu_op_t op;
    total_t  a;
    total_t  b;
  } alu_req_t;

endpackage

>>> design/gap_constrained_max_sum_dp.sv
// ----------------------------------------------------------------------------
// gap_constrained_max_sum_dp
// best chain total over a stream of amounts with a gap window between picks
// ----------------------------------------------------------------------------
// scan: one compare per cycle over the W history entries of the gap window
//   (0 to MAX_GAP), set by the single read port of the history ring
// items: one at a time; a new item is taken only in the idle state, after
//   the previous result is loaded into the output register
// reset: synchronous; gaps return to 1, counters and best total clear, the
//   history ring is not cleared (an entry is only read after it is written)
module gap_constrained_max_sum_dp #(
  parameter int MAX_GAP = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [8:0]  cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] amount, [23:20] zero
  input  logic        s_tlast,   // last_item
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [47:0] best_total
  output logic        m_tlast    // final_answer
);

  localparam int PTR_W = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
  localparam int D_W   = ($clog2(MAX_GAP + 2) > 9) ? $clog2(MAX_GAP + 2) : 9;
  localparam int A_W   = D_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_BEST = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state;
  gcms_pkg::gap_t     min_gap;
  gcms_pkg::gap_t     max_gap;
  gcms_pkg::amount_t  amount;
  logic               last;
  logic [D_W-1:0]     d;
  logic [D_W-1:0]     hi;
  logic               rd_pend;
  gcms_pkg::total_t   best;
  gcms_pkg::total_t   chain;
  gcms_pkg::total_t   running_best;
  logic [PTR_W-1:0]   slot;
  gcms_pkg::count_t   items_seen;

  logic               accept;
  logic [D_W-1:0]     lo_c;
  logic [D_W-1:0]     hi_cfg;
  logic [D_W-1:0]     hi_c;
  logic [A_W-1:0]     addr_sum;
  logic [PTR_W-1:0]   rd_addr;
  logic               rd_issue;
  gcms_pkg::total_t   rd_data;
  gcms_pkg::alu_req_t alu_req;
  gcms_pkg::total_t   alu_res;
  logic               out_free;

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // window bounds, clipped to the ring depth and to positions seen so far
  assign lo_c   = (min_gap == '0) ? D_W'(1) : D_W'(min_gap);
  assign hi_cfg = (D_W'(max_gap) > D_W'(MAX_GAP)) ? D_W'(MAX_GAP) : D_W'(max_gap);
  assign hi_c   = (32'(hi_cfg) > items_seen) ? D_W'(items_seen) : hi_cfg;

  // ring slot d positions back
  assign addr_sum = A_W'(slot) + A_W'(MAX_GAP) - A_W'(d);
  assign rd_addr  = (addr_sum >= A_W'(MAX_GAP)) ? PTR_W'(addr_sum - A_W'(MAX_GAP))
                                                : PTR_W'(addr_sum);
  assign rd_issue = (state == S_SCAN) && (d <= hi);

  gcms_hist #(
    .DEPTH (MAX_GAP),
    .AW    (PTR_W)
  ) u_hist (
    .clk   (clk),
    .we    (state == S_BEST),
    .waddr (slot),
    .wdata (chain),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    alu_req.op = gcms_pkg::OP_MAX;
    alu_req.a  = best;
    alu_req.b  = rd_data;
    unique case (state)
      S_ADD: begin
        alu_req.op = gcms_pkg::OP_ADD;
        alu_req.b  = gcms_pkg::TOTAL_W'(amount);
      end
      S_BEST: begin
        alu_req.a = running_best;
        alu_req.b = chain;
      end
      default: ;
    endcase
  end

  gcms_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= gcms_pkg::GAP_W'(1);
      max_gap <= gcms_pkg::GAP_W'(1);
    end else if (cfg_we) begin
      priority if (cfg_addr == gcms_pkg::REG_MIN_GAP) begin
        min_gap <= cfg_data;
      end else if (cfg_addr == gcms_pkg::REG_MAX_GAP) begin
        max_gap <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_pend      <= 1'b0;
      running_best <= '0;
      slot         <= '0;
      items_seen   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            amount <= s_tdata[gcms_pkg::AMOUNT_W-1:0];
            last   <= s_tlast;
            d      <= lo_c;
            hi     <= hi_c;
            best   <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // data read in the previous cycle is folded in now
          if (rd_pend) begin
            best <= alu_res;
          end
          rd_pend <= rd_issue;
          if (rd_issue) begin
            d <= d + D_W'(1);
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain <= alu_res;
          state <= S_BEST;
        end
        S_BEST: begin
          running_best <= alu_res;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= running_best;
            m_tlast  <= last;
            state    <= S_IDLE;
            if (last) begin
              items_seen   <= '0;
              running_best <= '0;
              slot         <= '0;
            end else begin
              slot <= (slot == PTR_W'(MAX_GAP - 1)) ? '0 : slot + PTR_W'(1);
              if (items_seen != '1) begin
                items_seen <= items_seen + gcms_pkg::COUNT_W'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/gcms_alu.sv
// ----------------------------------------------------------------------------
// gcms_alu
// shared 48-bit unit: maximum of two totals or saturating add
// ----------------------------------------------------------------------------
module gcms_alu (
  input  gcms_pkg::alu_req_t req,
  output gcms_pkg::total_t   res
);

  logic [gcms_pkg::TOTAL_W:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    unique case (req.op)
      gcms_pkg::OP_MAX: res = (req.a > req.b) ? req.a : req.b;
      gcms_pkg::OP_ADD: res = sum[gcms_pkg::TOTAL_W] ? '1 : sum[gcms_pkg::TOTAL_W-1:0];
    endcase
  end

endmodule

>>> design/gcms_hist.sv
// ----------------------------------------------------------------------------
// gcms_hist
// ring of recent chain values, one write and one registered read port
// ----------------------------------------------------------------------------
module gcms_hist #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  gcms_pkg::total_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output gcms_pkg::total_t rdata
);

  gcms_pkg::total_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/gcms_check.sv
// ----------------------------------------------------------------------------
// gcms_check
// port-level checks on the gap-constrained max-sum block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcms_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  logic [48:0] out_word;

  assign out_word = {m_tlast, m_tdata};

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(out_word))

  // reset empties the output register
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid)

  // one item at a time: busy straight after an accept
  `ASSERT_CLK(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready)

  // no item is taken while reset is high
  `ASSERT_ALWAYS(a_rst_not_ready, clk, rst |-> !s_tready)

endmodule

bind gap_constrained_max_sum_dp gcms_check u_check (.*);

>>> tb/gcms_checker.sv
// ----------------------------------------------------------------------------
// gcms_checker
// watches the gap-window max-sum block, predicts every result and compares
// ----------------------------------------------------------------------------
// follows register writes and accepted input items, keeps its own chain
// history ring, counters and gap settings, and checks each accepted result
// against the oldest awaited best total and end-of-set flag
module gcms_checker #(
  parameter int MAX_GAP = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] amount, [23:20] zero
  input  logic        s_tlast,   // last_item
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // [47:0] best_total
  input  logic        m_tlast,   // final_answer
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam gcms_pkg::total_t TOTAL_TOP = '1;

  typedef struct {
    gcms_pkg::total_t best_total;
    logic             final_answer;
  } outcome_t;

  gcms_pkg::total_t chain_ring [MAX_GAP];
  int unsigned      ring_wr;
  gcms_pkg::count_t seen_count;
  gcms_pkg::total_t set_best;
  gcms_pkg::gap_t   min_gap;
  gcms_pkg::gap_t   max_gap;
  outcome_t         awaited_q [$];

  task automatic report_mismatch(string what, gcms_pkg::total_t got,
                                 gcms_pkg::total_t want);
    $display("[%0t] mismatch, %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // best chain ending at this position, then the running best of the set
  function automatic outcome_t fold_amount(gcms_pkg::amount_t amount, logic last_item);
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      d;
    gcms_pkg::total_t best_prev;
    gcms_pkg::total_t chain;
    logic [48:0]      sum;
    outcome_t         o;
    lo = (min_gap == 0) ? 1 : min_gap;
    hi = (max_gap > MAX_GAP) ? MAX_GAP : max_gap;
    if (hi > seen_count) hi = seen_count;
    best_prev = '0;
    for (d = lo; d <= hi; d++) begin
      if (chain_ring[(ring_wr + MAX_GAP - d) % MAX_GAP] > best_prev)
        best_prev = chain_ring[(ring_wr + MAX_GAP - d) % MAX_GAP];
    end
    sum = {1'b0, best_prev} + {29'b0, amount};
    chain = (sum > {1'b0, TOTAL_TOP}) ? TOTAL_TOP : sum[47:0];
    chain_ring[ring_wr] = chain;
    ring_wr = (ring_wr + 1) % MAX_GAP;
    if (seen_count != '1) seen_count++;
    if (chain > set_best) set_best = chain;
    o.best_total = set_best;
    o.final_answer = last_item;
    // closing item starts a fresh set
    if (last_item) begin
      seen_count = '0;
      set_best = '0;
      ring_wr = 0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      ring_wr = 0;
      seen_count = '0;
      set_best = '0;
      min_gap = 9'd1;
      max_gap = 9'd1;
      mismatches = 0;
      awaited_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == gcms_pkg::REG_MIN_GAP) min_gap = cfg_data;
        else if (cfg_addr == gcms_pkg::REG_MAX_GAP) max_gap = cfg_data;
      end
      if (s_tvalid && s_tready)
        awaited_q.push_back(fold_amount(s_tdata[gcms_pkg::AMOUNT_W-1:0], s_tlast));
      if (m_tvalid && m_tready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with nothing awaited", m_tdata, '0);
        end else begin
          want = awaited_q.pop_front();
          if (m_tdata !== want.best_total)
            report_mismatch("best_total", m_tdata, want.best_total);
          if (m_tlast !== want.final_answer)
            report_mismatch("final_answer", gcms_pkg::total_t'(m_tlast),
                            gcms_pkg::total_t'(want.final_answer));
        end
      end
    end
    pending = awaited_q.size();
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the gap-window max-sum block
// ----------------------------------------------------------------------------
// a directed run over the gap corner cases precedes random phases, each with
// its own gap settings, random data sets and random idling on both streams
// but the last; the checker beside the block predicts and checks every result
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                MAX_GAP    = 256;
  localparam int                PHASES     = 10;
  localparam int                PHASE_LEN  = 200;
  localparam int unsigned       LIMIT      = 4_000_000;
  localparam gcms_pkg::amount_t AMOUNT_TOP = '1;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [8:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;
  int          mismatches;
  int          pending;

  int src_pace;    // 0 none, 1 light, 2 heavy
  int sink_pace;
  int set_left;

  always #1 clk = ~clk;

  gap_constrained_max_sum_dp #(.MAX_GAP(MAX_GAP)) uut (.*);

  gcms_checker #(.MAX_GAP(MAX_GAP)) u_checker (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .mismatches, .pending
  );

  // result side back-pressure in random bursts
  initial begin : sink_pacing
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (sink_pace != 0 && $urandom_range(0, 4 - sink_pace) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic offer_amount(gcms_pkg::amount_t amount, logic last_item);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, amount};
    s_tlast  <= last_item;
    do @(posedge clk); while (!s_tready);
  endtask

  // valid low for the requested time, junk on the data lines
  task automatic hold_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= {4'b0, gcms_pkg::amount_t'($urandom)};
      s_tlast  <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic drain_results();
    hold_sender(1);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_gaps(gcms_pkg::gap_t lo, gcms_pkg::gap_t hi);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= gcms_pkg::REG_MIN_GAP;
    cfg_data <= lo;
    @(negedge clk);
    cfg_addr <= gcms_pkg::REG_MAX_GAP;
    cfg_data <= hi;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic gcms_pkg::amount_t pick_amount();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return AMOUNT_TOP;
      2, 3:    return gcms_pkg::amount_t'($urandom_range(0, 15));
      default: return gcms_pkg::amount_t'($urandom);
    endcase
  endfunction

  // mostly short sets, some past the ring depth, some of one item
  function automatic int pick_set_len();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return $urandom_range(200, 400);
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  task automatic send_random(int count, int pause_at);
    int i;
    logic last_item;
    for (i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      if (src_pace != 0 && $urandom_range(0, 4 - src_pace) == 0)
        hold_sender($urandom_range(1, 4));
      if (set_left == 0) set_left = pick_set_len();
      last_item = (set_left == 1);
      set_left--;
      offer_amount(pick_amount(), last_item);
    end
  endtask

  initial begin : stimulus
    int             p;
    gcms_pkg::gap_t lo;
    gcms_pkg::gap_t hi;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = gcms_pkg::REG_MIN_GAP;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    src_pace  = 0;
    sink_pace = 0;
    set_left  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset gaps: adjacent picks, top amounts accumulate
    offer_amount('0, 1'b0);
    offer_amount(AMOUNT_TOP, 1'b0);
    offer_amount(AMOUNT_TOP, 1'b0);
    offer_amount(20'd1, 1'b1);
    offer_amount(AMOUNT_TOP, 1'b1);
    // zero min gap behaves as one
    write_gaps(9'd0, 9'd2);
    offer_amount(20'd5, 1'b0);
    offer_amount(20'd7, 1'b0);
    offer_amount(AMOUNT_TOP, 1'b0);
    offer_amount(20'd3, 1'b1);
    // max gap below min gap: empty window
    write_gaps(9'd3, 9'd2);
    offer_amount(20'd9, 1'b0);
    offer_amount(20'd4, 1'b0);
    offer_amount(20'd8, 1'b1);
    // gaps beyond the ring depth
    write_gaps(9'd300, 9'd511);
    offer_amount(20'd1, 1'b0);
    offer_amount(20'd2, 1'b0);
    offer_amount(20'd3, 1'b1);
    // wide window reaching before the start of the set
    write_gaps(9'd2, 9'd256);
    offer_amount(20'd10, 1'b0);
    offer_amount(20'd20, 1'b0);
    offer_amount(20'd30, 1'b0);
    offer_amount(20'd40, 1'b0);
    offer_amount('0, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo = 9'd1;   hi = 9'd1;   end
        1: begin lo = 9'd1;   hi = 9'd256; end
        2: begin lo = 9'd256; hi = 9'd256; end
        3: begin lo = 9'd0;   hi = 9'd511; end
        4: begin lo = 9'd511; hi = 9'd1;   end
        5: begin lo = 9'd2;   hi = 9'd3;   end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            lo = gcms_pkg::gap_t'($urandom);
            hi = gcms_pkg::gap_t'($urandom);
          end else begin
            lo = gcms_pkg::gap_t'($urandom_range(0, 16));
            hi = lo + gcms_pkg::gap_t'($urandom_range(0, 40));
          end
        end
      endcase
      write_gaps(lo, hi);
      // no idling in the closing phase
      src_pace  = (p == PHASES - 1) ? 0 : $urandom_range(0, 2);
      sink_pace = (p == PHASES - 1) ? 0 : $urandom_range(0, 2);
      send_random(PHASE_LEN, (p == 2) ? PHASE_LEN / 2 : -1);
    end

    hold_sender(1);
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/gcms_pkg.sv
design/gcms_alu.sv
design/gcms_hist.sv
design/gap_constrained_max_sum_dp.sv
design/gcms_check.sv
tb/gcms_checker.sv
tb/testbench.sv
